// ===== rtl/pob_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pob_pkg;
    localparam int SEQ_W = 32;
    localparam int SRC_W = 4;
    localparam int REP_W = 8;
    localparam int HDL_W = 16;
    localparam int CNT_W = 7;
    localparam int TIME_W = 32;
    localparam int PRE_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREBUFFER = 1'd1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_PLAY = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_READY = 3'd2;
    localparam logic [2:0] ST_PLAYED = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RELEASE,
        S_PLACE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [SRC_W-1:0] src;
        logic [REP_W-1:0] rep;
        logic [HDL_W-1:0] hdl;
    } t_desc;

    // control broadcast to every cell
    typedef struct packed {
        logic  shift_left;
        logic  place;
        t_desc desc;
    } t_cell_ctrl;
endpackage
`default_nettype wire

// ===== rtl/pob_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pob_in_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [pob_pkg::SEQ_W-1:0] seq_number;
    logic [pob_pkg::SRC_W-1:0] source_index;
    logic [pob_pkg::REP_W-1:0] repeat_count;
    logic [pob_pkg::HDL_W-1:0] payload_handle;
    logic [pob_pkg::TIME_W-1:0] now_ms;
    modport source (output valid, operation, seq_number, source_index, repeat_count,
        payload_handle, now_ms, input ready);
    modport sink (input valid, operation, seq_number, source_index, repeat_count,
        payload_handle, now_ms, output ready);
endinterface

interface pob_out_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic                      emitted;
    logic [pob_pkg::SEQ_W-1:0] out_seq;
    logic [pob_pkg::SRC_W-1:0] out_source;
    logic [pob_pkg::REP_W-1:0] out_repeat;
    logic [pob_pkg::HDL_W-1:0] out_handle;
    logic [pob_pkg::CNT_W-1:0] fill_count;
    modport source (output valid, status, emitted, out_seq, out_source, out_repeat,
        out_handle, fill_count, input ready);
    modport sink (input valid, status, emitted, out_seq, out_source, out_repeat,
        out_handle, fill_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/playout_reorder_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An insert steps through the release, place and done states of the sequencer
//   over the cell chain; a play request skips place. One request in flight at a time:
//   a new request is taken only in idle, after the last result has been accepted.
// Reset (synchronous, active low) clears count, ready flag, timestamps and
//   output state and loads the default fill limit and prebuffer; cell contents stay undefined until written.
module playout_reorder_buffer #(
    parameter int DEPTH = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    pob_in_if.sink                            in_if,
    pob_out_if.source                         out_if,
    input  wire                               i_cfg_we,
    input  wire [pob_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [pob_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int CW = $clog2(DEPTH + 1);

    pob_pkg::t_state r_state, n_state;

    // registers
    logic [pob_pkg::CNT_W-1:0]  r_fill_limit;
    logic [pob_pkg::PRE_W-1:0]  r_prebuf;
    logic [CW-1:0]              r_count;
    logic                       r_ready;
    logic [pob_pkg::TIME_W-1:0] r_first, r_last;

    // captured request
    logic                       r_op;
    pob_pkg::t_desc             r_new;
    logic [pob_pkg::TIME_W-1:0] r_now;

    // pending result
    logic [2:0]                 r_status;
    logic                       r_emit;
    pob_pkg::t_desc             r_out;
    logic                       r_ovalid;

    // per-cell compare flags registered between release and place
    logic [DEPTH-1:0]           r_hit;

    pob_pkg::t_desc             cell_q [DEPTH];
    pob_pkg::t_desc             cell_l [DEPTH];
    pob_pkg::t_desc             cell_r [DEPTH];
    logic [DEPTH-1:0]           at_ins, right_ins, hit_c, valid_c;
    pob_pkg::t_cell_ctrl        ctrl;

    logic [CW-1:0]              limit_eff;
    logic [pob_pkg::SRC_W-1:0]  src_in;
    logic                       acc;
    logic                       do_release;
    logic                       dup;
    logic                       head_before;

    assign acc = in_if.valid && in_if.ready;
    assign in_if.ready = (r_state == pob_pkg::S_IDLE) && !r_ovalid;

    // source width is the package source width
    assign src_in = in_if.source_index;

    // fill limit clamped to 1..DEPTH
    always_comb begin
        if (r_fill_limit == '0) begin
            limit_eff = CW'(1);
        end else if (32'(r_fill_limit) > DEPTH) begin
            limit_eff = CW'(DEPTH);
        end else begin
            limit_eff = CW'(r_fill_limit);
        end
    end

    assign do_release = (r_count != '0) && (r_count >= limit_eff);

    // chain neighbors and compare flags (count as seen at release time)
    for (genvar g = 0; g < DEPTH; g++) begin : g_cells
        assign cell_l[g] = (g == 0) ? r_new : cell_q[(g == 0) ? 0 : g - 1];
        assign cell_r[g] = (g == DEPTH - 1) ? cell_q[g] : cell_q[(g == DEPTH - 1) ? g : g + 1];
        assign valid_c[g] = (CW'(g) < r_count);
        assign hit_c[g] = valid_c[g] && (g != 0) && (cell_q[g].src == r_new.src)
            && (cell_q[g].seq >= r_new.seq);

        pob_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_at_ins    (at_ins[g]),
            .i_right_ins (right_ins[g]),
            .i_left      (cell_l[g]),
            .i_right     (cell_r[g]),
            .o_desc      (cell_q[g])
        );
    end

    assign head_before = (r_count != '0) && (cell_q[0].src == r_new.src)
        && (cell_q[0].seq > r_new.seq);

    // insert point: head when empty or before head, else first hit, or tail; prefix-or over registered hits
    logic [DEPTH-1:0] before_hit;
    logic [DEPTH-1:0] first_hit;
    always_comb begin
        before_hit[0] = 1'b0;
        for (int k = 1; k < DEPTH; k++) begin
            before_hit[k] = before_hit[k-1] | r_hit[k-1];
        end
        first_hit = r_hit & ~before_hit;
    end

    logic [DEPTH-1:0] dup_vec;
    for (genvar g = 0; g < DEPTH; g++) begin : g_dup
        assign dup_vec[g] = (cell_q[g].seq == r_new.seq);
    end

    logic any_hit;
    assign any_hit = |r_hit;
    assign dup = any_hit && !head_before && ((first_hit & dup_vec) != '0);

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (r_count == '0 || head_before) begin
                at_ins[k] = (k == 0);
                right_ins[k] = (k != 0);
            end else if (any_hit) begin
                at_ins[k] = first_hit[k];
                right_ins[k] = before_hit[k] && !first_hit[k];
            end else begin
                at_ins[k] = (CW'(k) == r_count);
                right_ins[k] = 1'b0;
            end
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pob_pkg::S_IDLE:    if (acc) n_state = pob_pkg::S_RELEASE;
            pob_pkg::S_RELEASE: n_state = (r_op == pob_pkg::OP_INSERT) ?
                pob_pkg::S_PLACE : pob_pkg::S_DONE;
            pob_pkg::S_PLACE:   n_state = pob_pkg::S_DONE;
            pob_pkg::S_DONE:    n_state = pob_pkg::S_IDLE;
            default:            n_state = pob_pkg::S_IDLE;
        endcase
    end

    // sequencer: outputs to the chain
    always_comb begin
        ctrl = '0;
        ctrl.desc = r_new;
        case (r_state)
            pob_pkg::S_RELEASE: begin
                if (r_op == pob_pkg::OP_INSERT) begin
                    ctrl.shift_left = do_release;
                end else begin
                    ctrl.shift_left = r_ready && (r_count != '0);
                end
            end
            pob_pkg::S_PLACE: ctrl.place = !dup && (r_count < CW'(DEPTH));
            default: ctrl = ctrl;
        endcase
    end

    logic release_now;
    assign release_now = (r_state == pob_pkg::S_RELEASE) && ctrl.shift_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pob_pkg::S_IDLE;
            r_fill_limit <= pob_pkg::CNT_W'(64);
            r_prebuf <= pob_pkg::PRE_W'(200);
            r_count <= '0;
            r_ready <= 1'b0;
            r_first <= '0;
            r_last <= '0;
            r_ovalid <= 1'b0;
            r_emit <= 1'b0;
            r_status <= pob_pkg::ST_INSERTED;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pob_pkg::CFG_FILL_LIMIT: r_fill_limit <= i_cfg_data[pob_pkg::CNT_W-1:0];
                    pob_pkg::CFG_PREBUFFER:  r_prebuf <= i_cfg_data;
                    default: r_prebuf <= r_prebuf;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                pob_pkg::S_IDLE: begin
                    // emitted holds while a result waits; cleared on a new request
                    if (acc) begin
                        r_emit <= 1'b0;
                    end
                end
                pob_pkg::S_RELEASE: begin
                    if (release_now) begin
                        r_emit <= 1'b1;
                        r_count <= r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            r_ready <= 1'b0;
                            r_first <= '0;
                            r_last <= '0;
                        end
                    end
                    if (r_op == pob_pkg::OP_PLAY) begin
                        if (!r_ready) begin
                            r_status <= pob_pkg::ST_NOT_READY;
                            if ((r_last - r_first) > pob_pkg::TIME_W'(r_prebuf)) begin
                                r_ready <= 1'b1;
                            end
                        end else if (r_count != '0) begin
                            r_status <= pob_pkg::ST_PLAYED;
                        end else begin
                            r_status <= pob_pkg::ST_EMPTY;
                        end
                    end
                end
                pob_pkg::S_PLACE: begin
                    if (r_count == '0) begin
                        r_count <= CW'(1);
                        r_first <= r_now;
                        r_last <= r_now;
                        r_status <= pob_pkg::ST_INSERTED;
                    end else if (dup) begin
                        r_status <= pob_pkg::ST_DUPLICATE;
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_last <= r_now;
                        r_status <= pob_pkg::ST_INSERTED;
                    end
                end
                pob_pkg::S_DONE: begin
                    r_ovalid <= 1'b1;
                end
                default: r_ovalid <= r_ovalid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op <= in_if.operation;
            r_new.seq <= in_if.seq_number;
            r_new.src <= src_in;
            r_new.rep <= in_if.repeat_count;
            r_new.hdl <= in_if.payload_handle;
            r_now <= in_if.now_ms;
            r_out <= '0;
        end
        if (release_now) begin
            r_out <= cell_q[0];
            // hits against post-release order, i.e. shifted by one
            for (int k = 0; k < DEPTH; k++) begin
                r_hit[k] <= (k < DEPTH - 1) && (k != 0) && hit_c[(k < DEPTH - 1) ? k + 1 : k]
                    && valid_c[(k < DEPTH - 1) ? k + 1 : k];
            end
        end else begin
            r_hit <= hit_c;
        end
    end

    assign out_if.valid = r_ovalid;
    assign out_if.status = r_status;
    assign out_if.emitted = r_emit;
    assign out_if.out_seq = r_emit ? r_out.seq : '0;
    assign out_if.out_source = r_emit ? r_out.src : '0;
    assign out_if.out_repeat = r_emit ? r_out.rep : '0;
    assign out_if.out_handle = r_emit ? r_out.hdl : '0;
    assign out_if.fill_count = pob_pkg::CNT_W'(r_count);

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("count above depth");
    a_rdy_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != pob_pkg::S_IDLE |-> !in_if.ready) else $error("ready while busy");
    a_empty_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> !r_ready) else $error("ready with empty list");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pob_pkg::S_DONE |=> r_ovalid) else $error("result lost");
endmodule
`default_nettype wire

// ===== rtl/pob_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One slot of the ordered list. Shifts left on release, shifts right or
// loads the new descriptor on placement.
module pob_cell (
    input  wire                  i_clk,
    input  pob_pkg::t_cell_ctrl  i_ctrl,
    input  wire                  i_at_ins,    // this slot takes the new entry
    input  wire                  i_right_ins, // slot is right of insert point
    input  pob_pkg::t_desc       i_left,
    input  pob_pkg::t_desc       i_right,
    output pob_pkg::t_desc       o_desc
);
    pob_pkg::t_desc r_desc;
    pob_pkg::t_desc n_desc;

    always_comb begin
        n_desc = r_desc;
        if (i_ctrl.shift_left) begin
            n_desc = i_right;
        end else if (i_ctrl.place) begin
            if (i_at_ins) begin
                n_desc = i_ctrl.desc;
            end else if (i_right_ins) begin
                n_desc = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
    end

    assign o_desc = r_desc;
endmodule
`default_nettype wire

// ===== tb/pob_tb_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces come with the RTL (rtl/pob_if.sv); this file only holds
// the shared request and response records used by the bench.
package pob_tb_pkg;
    import pob_pkg::*;

    typedef struct {
        logic              op;
        logic [SEQ_W-1:0]  seq;
        logic [SRC_W-1:0]  src;
        logic [REP_W-1:0]  rep;
        logic [HDL_W-1:0]  hdl;
        logic [TIME_W-1:0] now;
    } t_req;

    typedef struct {
        logic [2:0]       status;
        logic             emitted;
        logic [SEQ_W-1:0] seq;
        logic [SRC_W-1:0] src;
        logic [REP_W-1:0] rep;
        logic [HDL_W-1:0] hdl;
        logic [CNT_W-1:0] cnt;
    } t_rsp;
endpackage

// ===== tb/playout_reorder_buffer_test.sv =====
`timescale 1ns / 1ps
module playout_reorder_buffer_test;
    import pob_pkg::*;
    import pob_tb_pkg::*;

    localparam int DEPTH     = 64;
    localparam int N_RANDOM  = 620;
    localparam int MAX_CYC   = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pob_in_if  req_ch();
    pob_out_if rsp_ch();

    playout_reorder_buffer #(.DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_if(req_ch.sink), .out_if(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---- shadow of the buffer ----
    t_desc      shadow_q[$];
    logic       sh_ready;
    logic [31:0] sh_first, sh_last;
    logic [6:0] sh_limit;
    logic [15:0] sh_prebuf;

    t_rsp       pending_q[$];     // expected responses, oldest first
    int         errors = 0;
    int         n_sent = 0;
    bit         stim_done = 0;
    bit         hold_off = 0;     // long receiver stall for back-pressure

    task automatic shadow_reset();
        shadow_q = {};
        sh_ready = 0; sh_first = 0; sh_last = 0;
        sh_limit = 7'd64; sh_prebuf = 16'd200;
    endtask

    function automatic void pop_head(ref t_rsp r);
        t_desc h;
        h = shadow_q.pop_front();
        if (shadow_q.size() == 0) begin
            sh_ready = 0; sh_first = 0; sh_last = 0;
        end
        r.emitted = 1; r.seq = h.seq; r.src = h.src; r.rep = h.rep; r.hdl = h.hdl;
    endfunction

    // Predict the response to one request and advance the shadow state.
    function automatic t_rsp predict_playout(t_req q);
        t_rsp r;
        t_desc d;
        int lim, i;
        r = '{default: '0};
        if (q.op == OP_INSERT) begin
            d.seq = q.seq; d.src = q.src; d.rep = q.rep; d.hdl = q.hdl;
            lim = (sh_limit == 0) ? 1 : (sh_limit > DEPTH ? DEPTH : sh_limit);
            if (shadow_q.size() > 0 && shadow_q.size() >= lim) pop_head(r);
            r.status = ST_INSERTED;
            if (shadow_q.size() == 0) begin
                shadow_q.push_back(d);
                sh_first = q.now; sh_last = q.now;
            end else if (shadow_q[0].src == d.src && shadow_q[0].seq > d.seq) begin
                shadow_q.push_front(d);
                sh_last = q.now;
            end else begin
                i = 1;
                while (i < shadow_q.size() &&
                       !(shadow_q[i].src == d.src && shadow_q[i].seq >= d.seq)) i++;
                if (i < shadow_q.size() && shadow_q[i].seq == d.seq)
                    r.status = ST_DUPLICATE;
                else begin
                    shadow_q.insert(i, d);
                    sh_last = q.now;
                end
            end
        end else begin
            if (!sh_ready) begin
                if (32'(sh_last - sh_first) > {16'd0, sh_prebuf}) sh_ready = 1;
                r.status = ST_NOT_READY;
            end else if (shadow_q.size() > 0) begin
                pop_head(r);
                r.status = ST_PLAYED;
            end else r.status = ST_EMPTY;
        end
        r.cnt = 7'(shadow_q.size());
        return r;
    endfunction

    // ---- cycle limit ----
    int cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > MAX_CYC) begin
            $display("playout_reorder_buffer_test: done, errors");
            $finish;
        end
    end

    // ---- response side: random ready, compare on accept ----
    initial begin
        int w;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (w - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            check_response();
        end
    end

    task automatic check_response();
        t_rsp e;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected response status=%0d", $time, rsp_ch.status);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (rsp_ch.status !== e.status || rsp_ch.emitted !== e.emitted ||
            rsp_ch.out_seq !== e.seq || rsp_ch.out_source !== e.src ||
            rsp_ch.out_repeat !== e.rep || rsp_ch.out_handle !== e.hdl ||
            rsp_ch.fill_count !== e.cnt) begin
            $display("%0t: mismatch exp st=%0d em=%0b seq=%h src=%h rep=%h hdl=%h cnt=%0d",
                     $time, e.status, e.emitted, e.seq, e.src, e.rep, e.hdl, e.cnt);
            $display("%0t:          got st=%0d em=%0b seq=%h src=%h rep=%h hdl=%h cnt=%0d",
                     $time, rsp_ch.status, rsp_ch.emitted, rsp_ch.out_seq,
                     rsp_ch.out_source, rsp_ch.out_repeat, rsp_ch.out_handle,
                     rsp_ch.fill_count);
            errors++;
        end
    endtask

    // ---- request side ----
    // Drive one request after a random gap; predictor runs on acceptance.
    // Valid stays up after acceptance until the next gap or idle_request.
    task automatic send_request(t_req q, bit no_gap = 0);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 4);
        if (w > 0) begin
            req_ch.valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= q.op;
        req_ch.seq_number <= q.seq;
        req_ch.source_index <= q.src;
        req_ch.repeat_count <= q.rep;
        req_ch.payload_handle <= q.hdl;
        req_ch.now_ms <= q.now;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_q.push_back(predict_playout(q));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid; called at a falling edge while the block is busy.
    task automatic idle_request();
        req_ch.valid <= 1'b0;
    endtask

    // Wait until idle, plus the block's latency, then write a register.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        idle_request();
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FILL_LIMIT) sh_limit = val[6:0];
        else sh_prebuf = val;
    endtask

    function automatic t_req mk(logic op, logic [31:0] seq, logic [3:0] src,
                                logic [7:0] rep, logic [15:0] hdl, logic [31:0] now);
        t_req q;
        q.op = op; q.seq = seq; q.src = src; q.rep = rep; q.hdl = hdl; q.now = now;
        return q;
    endfunction

    // Random request, insert or play: mostly short in-order bursts per source
    // with jitter, sometimes duplicates, reversed order and far-off values.
    logic [31:0] clock_ms;
    logic [31:0] next_seq [16];
    function automatic t_req rand_request();
        t_req q;
        int s;
        s = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) s = $urandom_range(0, 15);
        clock_ms += $urandom_range(0, 40);
        q = mk(OP_INSERT, 0, 4'(s), 8'($urandom), 16'($urandom), clock_ms);
        if ($urandom_range(0, 2) == 0) q.op = OP_PLAY;
        case ($urandom_range(0, 9))
            0:       q.seq = $urandom;
            1:       q.seq = next_seq[s] - 32'($urandom_range(1, 4));   // repeat/late
            default: begin
                q.seq = next_seq[s] + 32'($urandom_range(0, 3));        // reorder
                next_seq[s] += 2;
            end
        endcase
        if ($urandom_range(0, 15) == 0) q.now = $urandom;
        return q;
    endfunction

    // Directed rows: expected given only where obvious; others go through predictor.
    typedef struct {
        t_req q;
        bit   known;
        logic [2:0] st;
        logic [6:0] cnt;
    } t_row;

    initial begin
        t_row rows[$];
        t_req q;
        t_rsp got_pred;
        int cfg_step;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.seq_number = '0;
        req_ch.source_index = '0;
        req_ch.repeat_count = '0;
        req_ch.payload_handle = '0;
        req_ch.now_ms = '0;
        shadow_reset();
        clock_ms = 0;
        foreach (next_seq[k]) next_seq[k] = 32'(k * 1000);
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // play after reset: not ready, nothing held
        rows.push_back('{mk(OP_PLAY, 0, 0, 0, 0, 0), 1, ST_NOT_READY, 0});
        rows.push_back('{mk(OP_INSERT, 32'hFFFF_FFFF, 4'hF, 8'hFF, 16'hFFFF, 0), 1, ST_INSERTED, 1});
        rows.push_back('{mk(OP_INSERT, 0, 4'hF, 0, 0, 10), 0, 0, 0});       // before head
        rows.push_back('{mk(OP_INSERT, 5, 4'h0, 8'h55, 16'hAAAA, 20), 0, 0, 0});
        rows.push_back('{mk(OP_INSERT, 5, 4'h0, 1, 1, 30), 1, ST_DUPLICATE, 3});
        rows.push_back('{mk(OP_INSERT, 3, 4'h0, 2, 2, 40), 0, 0, 0});
        rows.push_back('{mk(OP_INSERT, 0, 4'hF, 3, 3, 50), 0, 0, 0});       // head not dup-checked
        rows.push_back('{mk(OP_PLAY, 0, 0, 0, 0, 0), 1, ST_NOT_READY, 5});
        rows.push_back('{mk(OP_INSERT, 7, 4'h3, 4, 4, 32'hFFFF_FFFF), 0, 0, 0}); // span at maximum
        rows.push_back('{mk(OP_PLAY, 0, 0, 0, 0, 0), 0, 0, 0});             // becomes ready
        for (int k = 0; k < 7; k++) rows.push_back('{mk(OP_PLAY, 0, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(OP_PLAY, 0, 0, 0, 0, 0), 0, 0, 0});             // ready flag cleared
        foreach (rows[k]) begin
            send_request(rows[k].q);
            got_pred = pending_q[$];
            if (rows[k].known && (got_pred.status !== rows[k].st || got_pred.cnt !== rows[k].cnt))
                pending_q[$] = '{rows[k].st, 1'b0, 0, 0, 0, 0, rows[k].cnt};
        end

        // fill limit extremes, zero acting as one, above depth acting as depth
        write_reg(CFG_FILL_LIMIT, 16'd1);
        write_reg(CFG_PREBUFFER, 16'd0);
        for (int k = 0; k < 6; k++) send_request(rand_request());
        write_reg(CFG_FILL_LIMIT, 16'd0);
        for (int k = 0; k < 4; k++) send_request(rand_request());
        write_reg(CFG_FILL_LIMIT, 16'h7F);
        write_reg(CFG_PREBUFFER, 16'hFFFF);

        // back-pressure: receiver stalls, sender keeps offering
        hold_off = 1;
        for (int k = 0; k < 20; k++) send_request(rand_request(), 1);

        for (cfg_step = 0; cfg_step < 5; cfg_step++) begin
            case (cfg_step)
                0: begin write_reg(CFG_FILL_LIMIT, 16'd64); write_reg(CFG_PREBUFFER, 16'd200); end
                1: begin write_reg(CFG_FILL_LIMIT, 16'd4);  write_reg(CFG_PREBUFFER, 16'd30); end
                2: begin write_reg(CFG_FILL_LIMIT, 16'd12); write_reg(CFG_PREBUFFER, 16'd0); end
                3: begin write_reg(CFG_FILL_LIMIT, 16'd65); write_reg(CFG_PREBUFFER, 16'd500); end
                default: begin
                    write_reg(CFG_FILL_LIMIT, 16'($urandom_range(1, 64)));
                    write_reg(CFG_PREBUFFER, 16'($urandom));
                end
            endcase
            for (int k = 0; k < N_RANDOM / 5; k++) send_request(rand_request());
        end
        // some raw noise with all bits random
        for (int k = 0; k < 30; k++) begin
            q = mk(1'($urandom), $urandom, 4'($urandom), 8'($urandom), 16'($urandom), $urandom);
            send_request(q);
        end
        idle_request();

        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("playout_reorder_buffer_test: done, clean");
        else
            $display("playout_reorder_buffer_test: done, errors");
        $finish;
    end
endmodule
